// ===== sv/owrb_pkg.sv =====
// Shared types and codes for the overwriting RGB ring buffer with block average.
package owrb_pkg;

	localparam int CHAN_W = 16;

	typedef enum logic [1:0] {
		MODE_PUT = 2'd0,
		MODE_GET = 2'd1,
		MODE_AVG = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic en;
		rgb_t add;
		rgb_t sub;
	} sum_upd_t;

endpackage

// ===== sv/overwriting_rgb_ring_buffer_avg.sv =====
// Top level of the overwriting RGB ring buffer with block average.
//
// Input stream: s_axis_tuser carries the operation (put, get, average), s_axis_tdata the
// sample for a put. Output stream: one result transfer per input transfer, in order;
// m_axis_tdata carries the popped or averaged sample, m_axis_tuser the ok flag and the
// empty and full status after the operation.
// Each item is handled in two steps: the accepting cycle reads the sample memory at the head or
// tail and starts the average multiply, the write-back step writes back, moves the pointers
// and loads the output register. With that read-modify-write, no item is taken until
// the last is written back. Running sums of all slots are kept beside the memory, so an
// average costs no more than a put.
// A new item is accepted while the previous result still waits in the output register;
// if the receiver stalls, the block holds its write-back step until the output register
// frees, and accepts nothing further meanwhile.
// Reset empties the buffer, clears the running sums and marks every slot as zero, with
// no clearing pass; the block is ready for an item as soon as reset ends.
module overwriting_rgb_ring_buffer_avg #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // red_in, green_in, blue_in
	input  logic [1:0]  s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // red_out, green_out, blue_out
	output logic [2:0]  m_axis_tuser    // ok, now_empty, now_full
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t           state_q;
	owrb_pkg::mode_t  mode_s1;
	owrb_pkg::rgb_t   pix_s1;
	logic [AW-1:0]    wp_q, rp_q;
	logic             full_q;

	logic             out_vld_q;
	owrb_pkg::rgb_t   out_pix_q;
	logic             out_ok_q, out_empty_q, out_full_q;

	logic             in_acc, out_free, commit, empty_now;
	owrb_pkg::mode_t  in_mode;
	owrb_pkg::rgb_t   in_pix;
	logic [AW-1:0]    rd_addr;
	owrb_pkg::rgb_t   rd_data, avg;
	owrb_pkg::sum_upd_t upd;
	logic             wr_en;
	logic [AW-1:0]    wp_nx, rp_nx;
	logic             full_nx;
	logic             res_ok;
	owrb_pkg::rgb_t   res_pix;

	function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	assign in_mode      = owrb_pkg::mode_t'(s_axis_tuser);
	assign in_pix.red   = s_axis_tdata[15:0];
	assign in_pix.green = s_axis_tdata[31:16];
	assign in_pix.blue  = s_axis_tdata[47:32];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign commit        = (state_q == ST_WORK) && out_free;
	assign empty_now     = !full_q && (wp_q == rp_q);
	assign rd_addr       = (in_mode == owrb_pkg::MODE_PUT) ? wp_q : rp_q;

	owrb_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (pix_s1)
	);

	owrb_avg #(.DEPTH(DEPTH)) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.calc   (in_acc),
		.avg    (avg)
	);

	always_comb begin
		wp_nx      = wp_q;
		rp_nx      = rp_q;
		full_nx    = full_q;
		wr_en      = 1'b0;
		upd.en     = 1'b0;
		upd.add    = pix_s1;
		upd.sub    = rd_data;
		res_ok     = 1'b0;
		res_pix    = '0;
		unique case (mode_s1)
			owrb_pkg::MODE_PUT: begin
				// The old slot value leaves the running sums as the new sample enters.
				wr_en   = commit;
				upd.en  = commit;
				wp_nx   = next_pos(wp_q);
				rp_nx   = full_q ? next_pos(rp_q) : rp_q;
				full_nx = (wp_nx == rp_nx);
				res_ok  = 1'b1;
			end
			owrb_pkg::MODE_GET: begin
				if (!empty_now) begin
					rp_nx   = next_pos(rp_q);
					full_nx = 1'b0;
					res_ok  = 1'b1;
					res_pix = rd_data;
				end
			end
			owrb_pkg::MODE_AVG: begin
				if (!empty_now) begin
					res_ok  = 1'b1;
					res_pix = avg;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= in_mode;
			pix_s1  <= in_pix;
		end
		if (commit) begin
			out_pix_q   <= res_pix;
			out_ok_q    <= res_ok;
			out_empty_q <= !full_nx && (wp_nx == rp_nx);
			out_full_q  <= full_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			full_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				wp_q      <= wp_nx;
				rp_q      <= rp_nx;
				full_q    <= full_nx;
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
	assign m_axis_tuser  = {out_full_q, out_empty_q, out_ok_q};

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wp_q == rp_q))
		else $error("full flag set while head and tail differ");

	a_accept_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_WORK))
		else $error("accepted transfer did not start its write-back cycle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK && !out_free) |=> (state_q == ST_WORK) && $stable(wp_q)
			&& $stable(rp_q))
		else $error("write-back finished while the output register was busy");

	a_failed_get: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && mode_s1 == owrb_pkg::MODE_GET && empty_now) |=> $stable(rp_q)
			&& !out_ok_q)
		else $error("get on an empty buffer changed the tail or reported success");

endmodule

// ===== sv/owrb_store.sv =====
// Sample memory with one write and one registered read port; unwritten entries read as zero.
module owrb_store #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output owrb_pkg::rgb_t             rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  owrb_pkg::rgb_t             wr_data
);

	owrb_pkg::rgb_t   mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	owrb_pkg::rgb_t   rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// The valid flags reset to zero; an entry reads as zero until its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/owrb_avg.sv =====
// Running per-channel sums of all slots and the divide-by-depth unit.
module owrb_avg #(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  owrb_pkg::sum_upd_t  upd,
	input  logic                calc,
	output owrb_pkg::rgb_t      avg
);

	localparam int L  = $clog2(DEPTH);
	localparam int SW = owrb_pkg::CHAN_W + L;
	localparam int S  = SW + L;
	localparam int MW = SW + 2;
	localparam int PW = SW + MW;
	// Rounded-up reciprocal; exact floor division for every sum below 2**SW.
	localparam longint unsigned RECIP_FULL = ((64'd1 << S) + DEPTH - 1) / DEPTH;
	localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

	logic [SW-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [PW-1:0] prod_r_s1, prod_g_s1, prod_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else if (upd.en) begin
			sum_r_q <= sum_r_q + SW'(upd.add.red)   - SW'(upd.sub.red);
			sum_g_q <= sum_g_q + SW'(upd.add.green) - SW'(upd.sub.green);
			sum_b_q <= sum_b_q + SW'(upd.add.blue)  - SW'(upd.sub.blue);
		end
	end

	always_ff @(posedge clk) begin
		if (calc) begin
			prod_r_s1 <= PW'(sum_r_q) * PW'(RECIP);
			prod_g_s1 <= PW'(sum_g_q) * PW'(RECIP);
			prod_b_s1 <= PW'(sum_b_q) * PW'(RECIP);
		end
	end

	assign avg.red   = prod_r_s1[S +: owrb_pkg::CHAN_W];
	assign avg.green = prod_g_s1[S +: owrb_pkg::CHAN_W];
	assign avg.blue  = prod_b_s1[S +: owrb_pkg::CHAN_W];

endmodule
